// File: rtl/cell_library_token_lexer_assert.svh
// assertion macros shared by the lexer modules
// each use expects clk and rst_n in scope
`ifndef CELL_LIBRARY_TOKEN_LEXER_ASSERT_SVH
`define CELL_LIBRARY_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication
`define CLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/clt_pkg.sv
package clt_pkg;

  // lexer states
  typedef enum logic [3:0] {
    ST_START   = 4'd0,
    ST_IDENT   = 4'd1,
    ST_NUM     = 4'd2,
    ST_FRAC    = 4'd3,
    ST_EXP     = 4'd4,
    ST_EXPD    = 4'd5,
    ST_COMMENT = 4'd6,
    ST_QUOTE   = 4'd7,
    ST_LPOINT  = 4'd8
  } lex_state_t;

  // token kinds
  localparam logic [4:0] TK_END   = 5'd0;
  localparam logic [4:0] TK_SEMI  = 5'd1;
  localparam logic [4:0] TK_EQ    = 5'd2;
  localparam logic [4:0] TK_LP    = 5'd3;
  localparam logic [4:0] TK_RP    = 5'd4;
  localparam logic [4:0] TK_NOT   = 5'd5;
  localparam logic [4:0] TK_STAR  = 5'd6;
  localparam logic [4:0] TK_PLUS  = 5'd7;
  localparam logic [4:0] TK_HAT   = 5'd8;
  localparam logic [4:0] TK_KW0   = 5'd9;
  localparam logic [4:0] TK_STR   = 5'd16;
  localparam logic [4:0] TK_NUM   = 5'd17;
  localparam logic [4:0] TK_ERROR = 5'd18;

  // result kinds
  localparam logic RK_TEXT  = 1'b0;
  localparam logic RK_TOKEN = 1'b1;

  // keyword table
  localparam int KW_COUNT = 7;
  localparam logic [KW_COUNT-1:0] KW_ALL = '1;
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd4, 4'd3, 4'd6, 4'd3, 4'd7, 4'd6, 4'd6};
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"G", "A", "T", "E", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "I", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"N", "O", "N", "I", "N", "V", 8'h00, 8'h00},
    '{"I", "N", "V", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"U", "N", "K", "N", "O", "W", "N", 8'h00},
    '{"C", "O", "N", "S", "T", "0", 8'h00, 8'h00},
    '{"C", "O", "N", "S", "T", "1", 8'h00, 8'h00}
  };

  localparam logic [3:0] LEN_MAX = 4'd15;

  // queue geometry
  localparam int QAW    = 2;
  localparam int QDEPTH = 1 << QAW;

  // one result
  typedef struct packed {
    logic       kind;
    logic [4:0] tok;
    logic [7:0] ch;
  } res_t;

  // all results of one item, one or two
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  // queue side channel
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_port_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // drop keywords that the next identifier character rules out
  function automatic logic [KW_COUNT-1:0] kw_filter(logic [KW_COUNT-1:0] m, logic [3:0] len,
                                                   logic [7:0] c);
    logic [KW_COUNT-1:0] r;
    r = m;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (len >= KW_LEN[k] || KW_TEXT[k][len[2:0]] != c) r[k] = 1'b0;
    end
    return r;
  endfunction

  // token of a finished identifier, lowest keyword index wins
  function automatic logic [4:0] ident_tok(logic [KW_COUNT-1:0] m, logic [3:0] len);
    logic [4:0] t;
    t = TK_STR;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (m[k] && len == KW_LEN[k]) t = TK_KW0 + 5'(k);
    end
    return t;
  endfunction

  function automatic res_t mk_text(logic [7:0] c);
    res_t r;
    r.kind = RK_TEXT;
    r.tok  = TK_END;
    r.ch   = c;
    return r;
  endfunction

  function automatic res_t mk_tok(logic [4:0] t);
    res_t r;
    r.kind = RK_TOKEN;
    r.tok  = t;
    r.ch   = 8'h00;
    return r;
  endfunction

endpackage

// File: rtl/cell_library_token_lexer.sv
// Streaming lexer for a gate-library text format. Each input transfer carries one character
// byte, or an end-of-input mark; each output transfer carries either an echoed text character
// of the current token or a completed token kind, with last set on the final result of an item.
// The front end accepts one item per cycle whenever its four-entry queue has room and decodes
// it against the lexer state in that same cycle; the back end drains the queue at one result per
// cycle, while the receiver does not stall, through a registered output. An item yields at most
// one result, or two when a token ends and the same character starts the next one (or on end
// of input after an open token); sustained rate is one item per cycle for single-result streams
// while the receiver does not stall. Each result passes through queue storage and the output register.
module cell_library_token_lexer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_result_kind,
  output logic [4:0] out_token_kind,
  output logic [7:0] out_text_char,
  output logic       out_last
);

  clt_pkg::q_port_t push;
  clt_pkg::q_port_t head;
  logic             q_full;
  logic             pop;

  // character decode and lexer state
  clt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_end_of_input(in_end_of_input),
    .q_full         (q_full),
    .push           (push)
  );

  // result queue
  clt_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  // result serializer
  clt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_token_kind (out_token_kind),
    .out_text_char  (out_text_char),
    .out_last       (out_last)
  );

endmodule

// File: rtl/clt_front.sv
`include "cell_library_token_lexer_assert.svh"

module clt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_char_code,
  input  logic                in_end_of_input,
  input  logic                q_full,
  output clt_pkg::q_port_t    push
);

  clt_pkg::lex_state_t state_r, state_nxt;
  logic [clt_pkg::KW_COUNT-1:0] km_r, km_nxt;
  logic [3:0] len_r, len_nxt;

  logic acc;
  logic [7:0] c;

  // start-of-token decode
  logic                sc_emit;
  clt_pkg::res_t       sc_res;
  clt_pkg::lex_state_t sc_state;
  logic                sc_ident;

  logic [1:0]    n;
  clt_pkg::res_t r0, r1;
  logic          do_start;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign c        = in_char_code;

  // what a character does when it opens a token
  always_comb begin
    sc_emit  = 1'b1;
    sc_res   = clt_pkg::mk_tok(clt_pkg::TK_ERROR);
    sc_state = clt_pkg::ST_START;
    sc_ident = 1'b0;
    if (clt_pkg::is_alpha(c) || c == "_") begin
      sc_res   = clt_pkg::mk_text(c);
      sc_state = clt_pkg::ST_IDENT;
      sc_ident = 1'b1;
    end else if (clt_pkg::is_digit(c) || c == "-") begin
      sc_res   = clt_pkg::mk_text(c);
      sc_state = clt_pkg::ST_NUM;
    end else begin
      unique case (c)
        " ", 8'h09, 8'h0a: sc_emit = 1'b0;
        ".": begin
          sc_res   = clt_pkg::mk_text(c);
          sc_state = clt_pkg::ST_LPOINT;
        end
        "#": begin
          sc_emit  = 1'b0;
          sc_state = clt_pkg::ST_COMMENT;
        end
        "\"": begin
          sc_emit  = 1'b0;
          sc_state = clt_pkg::ST_QUOTE;
        end
        ";":      sc_res = clt_pkg::mk_tok(clt_pkg::TK_SEMI);
        "=":      sc_res = clt_pkg::mk_tok(clt_pkg::TK_EQ);
        "(":      sc_res = clt_pkg::mk_tok(clt_pkg::TK_LP);
        ")":      sc_res = clt_pkg::mk_tok(clt_pkg::TK_RP);
        "!":      sc_res = clt_pkg::mk_tok(clt_pkg::TK_NOT);
        "*", "&": sc_res = clt_pkg::mk_tok(clt_pkg::TK_STAR);
        "+", "|": sc_res = clt_pkg::mk_tok(clt_pkg::TK_PLUS);
        "^":      sc_res = clt_pkg::mk_tok(clt_pkg::TK_HAT);
        default:  sc_res = clt_pkg::mk_tok(clt_pkg::TK_ERROR);
      endcase
    end
  end

  // next state and results of the item
  always_comb begin
    state_nxt = state_r;
    km_nxt    = km_r;
    len_nxt   = len_r;
    n         = 2'd0;
    r0        = clt_pkg::mk_tok(clt_pkg::TK_END);
    r1        = clt_pkg::mk_tok(clt_pkg::TK_END);
    do_start  = 1'b0;

    if (in_end_of_input) begin
      unique case (state_r)
        clt_pkg::ST_IDENT: begin
          r0 = clt_pkg::mk_tok(clt_pkg::ident_tok(km_r, len_r));
          n  = 2'd1;
        end
        clt_pkg::ST_NUM, clt_pkg::ST_FRAC, clt_pkg::ST_EXP, clt_pkg::ST_EXPD: begin
          r0 = clt_pkg::mk_tok(clt_pkg::TK_NUM);
          n  = 2'd1;
        end
        clt_pkg::ST_QUOTE, clt_pkg::ST_LPOINT: begin
          r0 = clt_pkg::mk_tok(clt_pkg::TK_ERROR);
          n  = 2'd1;
        end
        default: n = 2'd0;
      endcase
      if (n == 2'd0) begin
        r0 = clt_pkg::mk_tok(clt_pkg::TK_END);
      end else begin
        r1 = clt_pkg::mk_tok(clt_pkg::TK_END);
      end
      n         = n + 2'd1;
      state_nxt = clt_pkg::ST_START;
      km_nxt    = clt_pkg::KW_ALL;
      len_nxt   = 4'd0;
    end else begin
      unique case (state_r)
        clt_pkg::ST_IDENT: begin
          if (clt_pkg::is_alpha(c) || clt_pkg::is_digit(c) || c == "_") begin
            km_nxt  = clt_pkg::kw_filter(km_r, len_r, c);
            len_nxt = (len_r < clt_pkg::LEN_MAX) ? len_r + 4'd1 : len_r;
            r0      = clt_pkg::mk_text(c);
            n       = 2'd1;
          end else begin
            r0       = clt_pkg::mk_tok(clt_pkg::ident_tok(km_r, len_r));
            n        = 2'd1;
            do_start = 1'b1;
          end
        end
        clt_pkg::ST_NUM, clt_pkg::ST_FRAC, clt_pkg::ST_EXP, clt_pkg::ST_EXPD: begin
          n  = 2'd1;
          r0 = clt_pkg::mk_text(c);
          if (clt_pkg::is_digit(c)) begin
            if (state_r == clt_pkg::ST_EXP) state_nxt = clt_pkg::ST_EXPD;
          end else if (c == "." && state_r == clt_pkg::ST_NUM) begin
            state_nxt = clt_pkg::ST_FRAC;
          end else if ((c == "E" || c == "e") &&
                       (state_r == clt_pkg::ST_NUM || state_r == clt_pkg::ST_FRAC)) begin
            state_nxt = clt_pkg::ST_EXP;
          end else if (c == "-" && state_r == clt_pkg::ST_EXP) begin
            state_nxt = clt_pkg::ST_EXPD;
          end else begin
            r0       = clt_pkg::mk_tok(clt_pkg::TK_NUM);
            do_start = 1'b1;
          end
        end
        clt_pkg::ST_LPOINT: begin
          n = 2'd1;
          if (clt_pkg::is_digit(c)) begin
            r0        = clt_pkg::mk_text(c);
            state_nxt = clt_pkg::ST_FRAC;
          end else begin
            r0        = clt_pkg::mk_tok(clt_pkg::TK_ERROR);
            state_nxt = clt_pkg::ST_START;
          end
        end
        clt_pkg::ST_COMMENT: begin
          if (c == 8'h0a) state_nxt = clt_pkg::ST_START;
        end
        clt_pkg::ST_QUOTE: begin
          n = 2'd1;
          if (c == "\"") begin
            r0        = clt_pkg::mk_tok(clt_pkg::TK_STR);
            state_nxt = clt_pkg::ST_START;
          end else begin
            r0 = clt_pkg::mk_text(c);
          end
        end
        default: do_start = 1'b1;
      endcase

      // character opens the next token
      if (do_start) begin
        state_nxt = sc_state;
        if (sc_ident) begin
          km_nxt  = clt_pkg::kw_filter(clt_pkg::KW_ALL, 4'd0, c);
          len_nxt = 4'd1;
        end
        if (sc_emit) begin
          if (n == 2'd0) begin
            r0 = sc_res;
          end else begin
            r1 = sc_res;
          end
          n = n + 2'd1;
        end
      end
    end
  end

  // queue write
  always_comb begin
    push.valid     = acc && (n != 2'd0);
    push.entry.two = (n == 2'd2);
    push.entry.r0  = r0;
    push.entry.r1  = r1;
  end

  // lexer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clt_pkg::ST_START;
      km_r    <= clt_pkg::KW_ALL;
      len_r   <= 4'd0;
    end else if (acc) begin
      state_r <= state_nxt;
      km_r    <= km_nxt;
      len_r   <= len_nxt;
    end
  end

  `CLT_ASSERT_NEXT(a_eoi_resets, acc && in_end_of_input, state_r == clt_pkg::ST_START && len_r == 4'd0 && km_r == clt_pkg::KW_ALL, "lexer state not back at start after end of input")
  `CLT_ASSERT_NOW(a_eoi_ends, acc && in_end_of_input, push.valid && ((push.entry.two ? push.entry.r1.tok : push.entry.r0.tok) == clt_pkg::TK_END), "end of input does not close with end token")

endmodule

// File: rtl/clt_queue.sv
`include "cell_library_token_lexer_assert.svh"

module clt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  clt_pkg::q_port_t push,
  output logic             full,
  output clt_pkg::q_port_t head,
  input  logic             pop
);

  clt_pkg::entry_t mem_r [clt_pkg::QDEPTH];
  logic [clt_pkg::QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [clt_pkg::QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [clt_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic                    empty;

  assign full  = (cnt_r == (clt_pkg::QAW + 1)'(clt_pkg::QDEPTH));
  assign empty = (cnt_r == '0);

  // head of queue
  always_comb begin
    head.valid = !empty;
    head.entry = mem_r[rd_ptr_r];
  end

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push.valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.entry;
  end

  `CLT_ASSERT_NOW(a_no_overflow, push.valid, !full, "write into a full queue")
  `CLT_ASSERT_NOW(a_no_underflow, pop, !empty, "read from an empty queue")

endmodule

// File: rtl/clt_back.sv
`include "cell_library_token_lexer_assert.svh"

module clt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  clt_pkg::q_port_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_result_kind,
  output logic [4:0]       out_token_kind,
  output logic [7:0]       out_text_char,
  output logic             out_last
);

  logic          half_r, half_nxt;
  logic          valid_r, valid_nxt;
  clt_pkg::res_t res_r;
  logic          last_r;

  logic          load;
  logic          is_last;
  clt_pkg::res_t pick;

  // pick the next result from the head entry
  always_comb begin
    load      = !valid_r || !out_stall;
    pick      = half_r ? head.entry.r1 : head.entry.r0;
    is_last   = half_r || !head.entry.two;
    pop       = load && head.valid && is_last;
    half_nxt  = (load && head.valid) ? !is_last : half_r;
    valid_nxt = load ? head.valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      res_r  <= pick;
      last_r <= is_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_result_kind = res_r.kind;
  assign out_token_kind  = res_r.tok;
  assign out_text_char   = res_r.ch;
  assign out_last        = last_r;

  `CLT_ASSERT_NOW(a_half_has_pair, half_r, head.valid && head.entry.two, "second result pending without a two-result entry")

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1450;
  localparam int CALM_ITEMS   = 150;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // letters and underscore first, digits last
  localparam string WORD_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
  localparam int WORD_LEADS = 53;
  localparam string PUNCT_CHARS = ";=()!*&+|^";

  typedef struct packed {
    logic       kind;
    logic [4:0] tok;
    logic [7:0] ch;
    logic       last;
  } lex_result_t;

  // lexer state tracking and result matching
  class lexer_scoreboard;
    string kw_words[clt_pkg::KW_COUNT] =
      '{"GATE", "PIN", "NONINV", "INV", "UNKNOWN", "CONST0", "CONST1"};

    clt_pkg::lex_state_t          st;
    logic [clt_pkg::KW_COUNT-1:0] kw_hits;
    logic [3:0]                   id_len;
    lex_result_t                  due_results[$];

    int errors;
    int n_chars;
    int n_ends;
    int n_checked;
    int n_tokens;

    function new();
      reset_state();
    endfunction

    function void reset_state();
      st      = clt_pkg::ST_START;
      kw_hits = '1;
      id_len  = '0;
    endfunction

    function bit letter_char(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit digit_char(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void push_text(logic [7:0] c);
      due_results.push_back('{kind: clt_pkg::RK_TEXT, tok: clt_pkg::TK_END, ch: c, last: 1'b0});
    endfunction

    function void push_token(logic [4:0] t);
      due_results.push_back('{kind: clt_pkg::RK_TOKEN, tok: t, ch: 8'h00, last: 1'b0});
    endfunction

    // narrow the keyword candidates by one more identifier character
    function void ident_char(logic [7:0] c);
      for (int k = 0; k < clt_pkg::KW_COUNT; k++) begin
        if (id_len >= kw_words[k].len() || 8'(kw_words[k][id_len]) != c) kw_hits[k] = 1'b0;
      end
      if (id_len != 4'd15) id_len = id_len + 4'd1;
    endfunction

    function logic [4:0] ident_kind();
      for (int k = 0; k < clt_pkg::KW_COUNT; k++) begin
        if (kw_hits[k] && id_len == kw_words[k].len()) return clt_pkg::TK_KW0 + 5'(k);
      end
      return clt_pkg::TK_STR;
    endfunction

    // character seen between tokens
    function void begin_token(logic [7:0] c);
      st = clt_pkg::ST_START;
      if (letter_char(c) || c == "_") begin
        kw_hits = '1;
        id_len  = '0;
        ident_char(c);
        push_text(c);
        st = clt_pkg::ST_IDENT;
      end else if (digit_char(c) || c == "-") begin
        push_text(c);
        st = clt_pkg::ST_NUM;
      end else begin
        case (c)
          " ", CH_TAB, CH_NL: ;
          ".": begin
            push_text(c);
            st = clt_pkg::ST_LPOINT;
          end
          "#":      st = clt_pkg::ST_COMMENT;
          CH_QUOTE: st = clt_pkg::ST_QUOTE;
          ";":      push_token(clt_pkg::TK_SEMI);
          "=":      push_token(clt_pkg::TK_EQ);
          "(":      push_token(clt_pkg::TK_LP);
          ")":      push_token(clt_pkg::TK_RP);
          "!":      push_token(clt_pkg::TK_NOT);
          "*", "&": push_token(clt_pkg::TK_STAR);
          "+", "|": push_token(clt_pkg::TK_PLUS);
          "^":      push_token(clt_pkg::TK_HAT);
          default:  push_token(clt_pkg::TK_ERROR);
        endcase
      end
    endfunction

    // accepted input transfer: predict its results
    function void note_char(logic [7:0] c, logic eoi);
      int          first;
      lex_result_t tail;
      first = due_results.size();
      if (eoi) begin
        n_ends++;
        case (st)
          clt_pkg::ST_IDENT: push_token(ident_kind());
          clt_pkg::ST_NUM, clt_pkg::ST_FRAC, clt_pkg::ST_EXP, clt_pkg::ST_EXPD:
            push_token(clt_pkg::TK_NUM);
          clt_pkg::ST_QUOTE, clt_pkg::ST_LPOINT: push_token(clt_pkg::TK_ERROR);
          default: ;
        endcase
        push_token(clt_pkg::TK_END);
        reset_state();
      end else begin
        n_chars++;
        case (st)
          clt_pkg::ST_IDENT: begin
            if (letter_char(c) || digit_char(c) || c == "_") begin
              ident_char(c);
              push_text(c);
            end else begin
              push_token(ident_kind());
              begin_token(c);
            end
          end
          clt_pkg::ST_NUM, clt_pkg::ST_FRAC, clt_pkg::ST_EXP, clt_pkg::ST_EXPD: begin
            if (digit_char(c)) begin
              push_text(c);
              if (st == clt_pkg::ST_EXP) st = clt_pkg::ST_EXPD;
            end else if (c == "." && st == clt_pkg::ST_NUM) begin
              push_text(c);
              st = clt_pkg::ST_FRAC;
            end else if ((c == "E" || c == "e") &&
                         (st == clt_pkg::ST_NUM || st == clt_pkg::ST_FRAC)) begin
              push_text(c);
              st = clt_pkg::ST_EXP;
            end else if (c == "-" && st == clt_pkg::ST_EXP) begin
              push_text(c);
              st = clt_pkg::ST_EXPD;
            end else begin
              push_token(clt_pkg::TK_NUM);
              begin_token(c);
            end
          end
          clt_pkg::ST_LPOINT: begin
            if (digit_char(c)) begin
              push_text(c);
              st = clt_pkg::ST_FRAC;
            end else begin
              push_token(clt_pkg::TK_ERROR);
              st = clt_pkg::ST_START;
            end
          end
          clt_pkg::ST_COMMENT: if (c == CH_NL) st = clt_pkg::ST_START;
          clt_pkg::ST_QUOTE: begin
            if (c == CH_QUOTE) begin
              push_token(clt_pkg::TK_STR);
              st = clt_pkg::ST_START;
            end else begin
              push_text(c);
            end
          end
          default: begin_token(c);
        endcase
      end
      // mark the final result of this item
      if (due_results.size() > first) begin
        tail = due_results.pop_back();
        tail.last = 1'b1;
        due_results.push_back(tail);
      end
    endfunction

    // accepted output transfer: compare with the oldest prediction
    function void check_result(lex_result_t got);
      lex_result_t want;
      n_checked++;
      if (got.kind == clt_pkg::RK_TOKEN) n_tokens++;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result kind=%0d tok=%0d char=%02h last=%0d",
                   $time, got.kind, got.tok, got.ch, got.last);
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.tok !== want.tok || got.ch !== want.ch ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: mismatch, expected kind=%0d tok=%0d char=%02h last=%0d,",
                    " got kind=%0d tok=%0d char=%02h last=%0d"},
                   $time, want.kind, want.tok, want.ch, want.last,
                   got.kind, got.tok, got.ch, got.last);
      end
    endfunction

    function void close_out();
      if (due_results.size() != 0) begin
        errors += due_results.size();
        $display("%0d predicted results never arrived", due_results.size());
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code    = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall       = 1'b0;
  logic       out_result_kind;
  logic [4:0] out_token_kind;
  logic [7:0] out_text_char;
  logic       out_last;

  lexer_scoreboard sb = new;
  bit calm = 1'b0;
  int idle_run = 0;

  cell_library_token_lexer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_token_kind  (out_token_kind),
    .out_text_char   (out_text_char),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transfer monitor on both channels
  always @(posedge clk) begin
    lex_result_t seen;
    seen = '{kind: out_result_kind, tok: out_token_kind, ch: out_text_char, last: out_last};
    if (rst_n && in_valid && !in_stall) sb.note_char(in_char_code, in_end_of_input);
    if (rst_n && out_valid && !out_stall) sb.check_result(seen);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run <= 0;
    else idle_run <= idle_run + 1;
  end

  // hang detection
  initial begin
    while (idle_run < IDLE_LIMIT) @(posedge clk);
    $display("no transfer for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver back-pressure in random bursts
  initial begin
    @(posedge clk);
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // one input transfer, with an occasional idle burst ahead of it
  task automatic send_item(input logic [7:0] c, input logic eoi);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_char_code    <= c;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(8'(s[i]), 1'b0);
  endtask

  // one mostly well-formed token with random content
  task automatic send_random_token();
    logic [7:0] text[$];
    string      w;
    int         n;
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1: begin
        // keyword, sometimes cut short or extended
        w = sb.kw_words[$urandom_range(0, clt_pkg::KW_COUNT - 1)];
        n = w.len();
        if ($urandom_range(0, 3) == 0) n = n - 1;
        for (int i = 0; i < n; i++) text.push_back(8'(w[i]));
        if ($urandom_range(0, 3) == 0)
          text.push_back(8'(WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]));
      end
      2: begin
        n = $urandom_range(1, 18);
        text.push_back(8'(WORD_CHARS[$urandom_range(0, WORD_LEADS - 1)]));
        for (int i = 1; i < n; i++)
          text.push_back(8'(WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]));
      end
      3, 4: begin
        // number: leading point, or optional minus, digits and fraction, then an optional exponent
        if ($urandom_range(0, 5) == 0) begin
          text.push_back(".");
          repeat ($urandom_range(0, 3)) text.push_back(8'("0" + $urandom_range(0, 9)));
        end else begin
          if ($urandom_range(0, 3) == 0) text.push_back("-");
          repeat ($urandom_range(text.size() == 0 ? 1 : 0, 4))
            text.push_back(8'("0" + $urandom_range(0, 9)));
          if ($urandom_range(0, 2) == 0) begin
            text.push_back(".");
            repeat ($urandom_range(0, 3)) text.push_back(8'("0" + $urandom_range(0, 9)));
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          text.push_back($urandom_range(0, 1) ? 8'("e") : 8'("E"));
          if ($urandom_range(0, 1) == 0) text.push_back("-");
          repeat ($urandom_range(0, 3)) text.push_back(8'("0" + $urandom_range(0, 9)));
        end
      end
      5, 6: text.push_back(8'(PUNCT_CHARS[$urandom_range(0, PUNCT_CHARS.len() - 1)]));
      7: begin
        // quoted string with any bytes but a quote, mostly closed
        text.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          b = 8'($urandom_range(0, 255));
          text.push_back(b == CH_QUOTE ? 8'h00 : b);
        end
        if ($urandom_range(0, 7) != 0) text.push_back(CH_QUOTE);
      end
      8: begin
        text.push_back("#");
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom_range(0, 255));
          text.push_back(b == CH_NL ? 8'hFF : b);
        end
        text.push_back(CH_NL);
      end
      default: text.push_back(8'($urandom_range(0, 255)));
    endcase
    foreach (text[i]) send_item(text[i], 1'b0);
  endtask

  // stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, lone minus, bad leading point, & and |,
    // quoted byte, comment, keyword, full number, open string at end
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("-;.a&|");
    send_item(CH_QUOTE, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item("#", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(CH_NL, 1'b0);
    send_text("INV(-.5e-3)");
    send_item(CH_QUOTE, 1'b0);
    send_item(8'hFF, 1'b1);

    // random token stream with separators and end marks
    while (sb.n_chars + sb.n_ends < RANDOM_ITEMS) begin
      if (sb.n_chars + sb.n_ends > RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_random_token();
      case ($urandom_range(0, 7))
        0, 1, 2: ;
        3:       send_item(CH_TAB, 1'b0);
        4:       send_item(CH_NL, 1'b0);
        default: send_item(" ", 1'b0);
      endcase
      if ($urandom_range(0, 39) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;

    // drain
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();

    $display("lexed %0d characters and %0d end marks; %0d results checked, %0d of them tokens",
             sb.n_chars, sb.n_ends, sb.n_checked, sb.n_tokens);
    $display("%0d failures", sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
